// ===== rtl/bbc_pkg.sv =====
// Shared types and constants for the block buffer cache.
// Used by the RAM-backed datapath, the controller and the top level.
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int unsigned DEFAULT_BUFFERS = 32;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned DEV_W    = 8;
  localparam int unsigned BLK_W    = 32;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned REFS_W   = 8;
  localparam int unsigned STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PIN     = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDER  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVER   = 2'd3;

  localparam logic [REFS_W-1:0] REFS_MAX = 8'hFF;

  // One cache entry as stored in the entry RAM.
  typedef struct packed {
    logic              valid;
    logic [DEV_W-1:0]  device;
    logic [BLK_W-1:0]  block;
    logic [REFS_W-1:0] refs;
    logic [TICK_W-1:0] stamp;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_SLOT,
    S_FINISH
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic slot_rd;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/block_buffer_cache_lru.sv =====
// Top level of the block buffer cache with reference counts and LRU reuse.
// Depends on bbc_pkg, bbc_ctrl, bbc_dp and bbc_ram.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_stall_o   mode, device, block_number,
//                                               buffer_slot, now_tick
//   out      output     out_valid_o/out_stall_i slot_out, was_hit,
//                                               needs_read, status
//
// An acquire reads every entry once through the single read port of the
// entry RAM, then the pick is written back.
// Release and pin do one entry read and one write.
// Reset clears the per-entry written flags at once; no clearing pass is needed.
// A stalled result holds in the output register; the next request is taken
// meanwhile and waits only at its write-back step.
`timescale 1ns / 1ps

module block_buffer_cache_lru #(
  parameter int unsigned BUFFERS = bbc_pkg::DEFAULT_BUFFERS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bbc_pkg::MODE_W-1:0]   in_mode_i,
  input  logic [bbc_pkg::DEV_W-1:0]    in_device_i,
  input  logic [bbc_pkg::BLK_W-1:0]    in_block_number_i,
  input  logic [bbc_pkg::SLOT_W-1:0]   in_buffer_slot_i,
  input  logic [bbc_pkg::TICK_W-1:0]   in_now_tick_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bbc_pkg::SLOT_W-1:0]   out_slot_out_o,
  output logic                         out_was_hit_o,
  output logic                         out_needs_read_o,
  output logic [bbc_pkg::STATUS_W-1:0] out_status_o
);

  import bbc_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_status;

  bbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_mode_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (dp_status)
  );

  bbc_dp #(
    .BUFFERS (BUFFERS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_mode_i         (in_mode_i),
    .in_device_i       (in_device_i),
    .in_block_number_i (in_block_number_i),
    .in_buffer_slot_i  (in_buffer_slot_i),
    .in_now_tick_i     (in_now_tick_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_slot_out_o    (out_slot_out_o),
    .out_was_hit_o     (out_was_hit_o),
    .out_needs_read_o  (out_needs_read_o),
    .out_status_o      (out_status_o),
    .cmd_i             (cmd),
    .status_o          (dp_status)
  );

  // A write-back never overwrites a result that is still being held.
  a_finish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

  // Once a transaction is accepted the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a request is in progress");

  // A new result only appears right after a write-back step.
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.finish))
    else $error("result shown without a finishing step");

  // After the write-back the block is ready for the next transaction.
  a_idle_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> !in_stall_o)
    else $error("block not ready after finishing a request");

endmodule

// ===== rtl/bbc_ram.sv =====
// Generic simple dual-port RAM with registered read data.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module bbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bbc_ctrl.sv =====
// Request sequencer for the block buffer cache.
// Depends on bbc_pkg for the state, command and status types.
`timescale 1ns / 1ps

module bbc_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [bbc_pkg::MODE_W-1:0] in_mode_i,
  output logic                       in_stall_o,
  output bbc_pkg::cmd_t              cmd_o,
  input  bbc_pkg::dp_status_t        status_i
);

  import bbc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_mode_i == MODE_ACQUIRE) ? S_SCAN : S_SLOT;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_LAST;
        end
      end
      // The read data of the last entry is folded into the search here.
      S_LAST: begin
        state_d = S_FINISH;
      end
      S_SLOT: begin
        cmd_o.slot_rd = 1'b1;
        state_d       = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bbc_dp.sv =====
// Datapath of the block buffer cache: request registers, entry RAM,
// tag/LRU search over the scanned entries, update logic and result register.
// Depends on bbc_pkg and bbc_ram.
`timescale 1ns / 1ps

module bbc_dp #(
  parameter int unsigned BUFFERS = bbc_pkg::DEFAULT_BUFFERS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bbc_pkg::MODE_W-1:0]   in_mode_i,
  input  logic [bbc_pkg::DEV_W-1:0]    in_device_i,
  input  logic [bbc_pkg::BLK_W-1:0]    in_block_number_i,
  input  logic [bbc_pkg::SLOT_W-1:0]   in_buffer_slot_i,
  input  logic [bbc_pkg::TICK_W-1:0]   in_now_tick_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bbc_pkg::SLOT_W-1:0]   out_slot_out_o,
  output logic                         out_was_hit_o,
  output logic                         out_needs_read_o,
  output logic [bbc_pkg::STATUS_W-1:0] out_status_o,
  input  bbc_pkg::cmd_t                cmd_i,
  output bbc_pkg::dp_status_t          status_o
);

  import bbc_pkg::*;

  localparam int unsigned IDX_W = $clog2(BUFFERS);
  localparam int unsigned CMP_W = SLOT_W + 9;

  // Request registers.
  logic [MODE_W-1:0] mode_q;
  logic [DEV_W-1:0]  dev_q;
  logic [BLK_W-1:0]  blk_q;
  logic [SLOT_W-1:0] slot_q;
  logic [TICK_W-1:0] now_q;

  // Scan and read tracking.
  logic [IDX_W-1:0] scan_cnt_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_scan_q;
  logic [BUFFERS-1:0] written_q;

  // Search results.
  logic              hit_found_q;
  logic [IDX_W-1:0]  hit_idx_q;
  entry_t            hit_entry_q;
  logic              free_found_q;
  logic [IDX_W-1:0]  free_idx_q;
  logic [TICK_W-1:0] best_stamp_q;

  // Result register.
  logic                out_valid_q;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic                res_hit_q, res_hit_d;
  logic                res_read_q, res_read_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;

  logic [IDX_W+SLOT_W-1:0] slot_ext;
  logic [IDX_W-1:0]        slot_idx;
  logic                    slot_in_range;
  logic [IDX_W-1:0]        raddr;
  logic                    re;
  logic [ENTRY_W-1:0]      rdata;
  entry_t                  ram_entry;
  entry_t                  cur_entry;
  entry_t                  reset_entry;
  logic                    we;
  logic [IDX_W-1:0]        waddr;
  entry_t                  wentry;
  logic [IDX_W-1:0]        res_idx;
  logic [IDX_W+SLOT_W-1:0] res_idx_ext;

  assign slot_ext      = {{IDX_W{1'b0}}, slot_q};
  assign slot_idx      = slot_ext[IDX_W-1:0];
  assign slot_in_range = CMP_W'(slot_q) < CMP_W'(BUFFERS);

  assign re    = cmd_i.scan_rd | cmd_i.slot_rd;
  assign raddr = cmd_i.scan_rd ? scan_cnt_q : slot_idx;

  bbc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BUFFERS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // An entry that was never written reads as its reset contents.
  always_comb begin
    ram_entry         = entry_t'(rdata);
    reset_entry       = '0;
    reset_entry.block = BLK_W'(rd_idx_q);
    cur_entry         = written_q[rd_idx_q] ? ram_entry : reset_entry;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_mode_i;
      dev_q  <= in_device_i;
      blk_q  <= in_block_number_i;
      slot_q <= in_buffer_slot_i;
      now_q  <= in_now_tick_i;
    end
    if (re) begin
      rd_idx_q <= raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      rd_scan_q  <= 1'b0;
      written_q  <= '0;
    end else begin
      rd_scan_q <= cmd_i.scan_rd;
      if (cmd_i.load) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.scan_rd) begin
        scan_cnt_q <= scan_cnt_q + IDX_W'(1);
      end
      if (we) begin
        written_q[waddr] <= 1'b1;
      end
    end
  end

  assign status_o.scan_last = (scan_cnt_q == IDX_W'(BUFFERS - 1));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  // Entries arrive in ascending order, so the first match wins and a strict
  // compare keeps the lowest index among equal stamps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (rd_scan_q) begin
      if (!hit_found_q && cur_entry.device == dev_q && cur_entry.block == blk_q) begin
        hit_found_q <= 1'b1;
      end
      if (cur_entry.refs == '0 &&
          (!free_found_q || cur_entry.stamp < best_stamp_q)) begin
        free_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_scan_q && !cmd_i.load) begin
      if (!hit_found_q && cur_entry.device == dev_q && cur_entry.block == blk_q) begin
        hit_idx_q   <= rd_idx_q;
        hit_entry_q <= cur_entry;
      end
      if (cur_entry.refs == '0 &&
          (!free_found_q || cur_entry.stamp < best_stamp_q)) begin
        free_idx_q   <= rd_idx_q;
        best_stamp_q <= cur_entry.stamp;
      end
    end
  end

  // Final decision and write-back.
  always_comb begin
    we           = 1'b0;
    waddr        = slot_idx;
    wentry       = cur_entry;
    res_idx      = slot_idx;
    res_slot_d   = slot_q;
    res_hit_d    = 1'b0;
    res_read_d   = 1'b0;
    res_status_d = STATUS_OK;
    if (mode_q == MODE_ACQUIRE) begin
      if (hit_found_q) begin
        res_idx   = hit_idx_q;
        res_hit_d = 1'b1;
        if (hit_entry_q.refs == REFS_MAX) begin
          res_status_d = STATUS_OVER;
        end else begin
          res_read_d   = !hit_entry_q.valid;
          we           = cmd_i.finish;
          waddr        = hit_idx_q;
          wentry       = hit_entry_q;
          wentry.refs  = hit_entry_q.refs + REFS_W'(1);
          wentry.valid = 1'b1;
        end
      end else if (free_found_q) begin
        res_idx       = free_idx_q;
        res_read_d    = 1'b1;
        we            = cmd_i.finish;
        waddr         = free_idx_q;
        wentry.valid  = 1'b1;
        wentry.device = dev_q;
        wentry.block  = blk_q;
        wentry.refs   = REFS_W'(1);
        wentry.stamp  = best_stamp_q;
      end else begin
        res_idx      = '0;
        res_status_d = STATUS_NOFREE;
      end
      res_idx_ext = {{SLOT_W{1'b0}}, res_idx};
      res_slot_d  = res_idx_ext[SLOT_W-1:0];
    end else begin
      res_idx_ext = '0;
      if (slot_in_range) begin
        case (mode_q)
          MODE_RELEASE: begin
            if (cur_entry.refs == '0) begin
              res_status_d = STATUS_UNDER;
            end else begin
              we          = cmd_i.finish;
              wentry.refs = cur_entry.refs - REFS_W'(1);
              if (cur_entry.refs == REFS_W'(1)) begin
                wentry.stamp = now_q;
              end
            end
          end
          MODE_PIN: begin
            if (cur_entry.refs == REFS_MAX) begin
              res_status_d = STATUS_OVER;
            end else begin
              we          = cmd_i.finish;
              wentry.refs = cur_entry.refs + REFS_W'(1);
            end
          end
          default: begin
            we = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_slot_q   <= res_slot_d;
      res_hit_q    <= res_hit_d;
      res_read_q   <= res_read_d;
      res_status_q <= res_status_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_slot_out_o   = res_slot_q;
  assign out_was_hit_o    = res_hit_q;
  assign out_needs_read_o = res_read_q;
  assign out_status_o     = res_status_q;

endmodule
